FILE: design/gdds_pkg.sv
// shared types, constants and calendar functions for the gregorian date day shifter
package gdds_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 17;
    localparam int DIST_W  = 22;
    localparam int SER_W   = 23;   // serial day number up to the largest year the fields hold
    localparam int WDAY_W  = 18;   // signed running day count during a month walk

    localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
    localparam logic [YEAR_W-1:0]  MIN_YEAR   = 14'd1;
    localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;
    localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;
    localparam logic [DIST_W-1:0]  DIST_MAX   = {DIST_W{1'b1}};

    // floor(y/100) = (y * RECIP_100) >> RECIP_SHIFT, exact for 14-bit y
    localparam int                 RECIP_SHIFT = 19;
    localparam logic [12:0]        RECIP_100   = 13'd5243;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_SHIFT = 2'd1,
        KIND_CMP   = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_CMP0,
        S_CMP1,
        S_CMP2,
        S_CMP3,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // floor(y/100) by reciprocal multiply
    function automatic logic [7:0] f_div100(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        begin
            prod = 27'(y) * 27'(RECIP_100);
            return prod[RECIP_SHIFT +: 8];
        end
    endfunction

    function automatic logic f_leap(input logic [YEAR_W-1:0] y);
        logic [7:0]        q;
        logic [YEAR_W-1:0] r;
        begin
            q = f_div100(y);
            r = y - YEAR_W'(q) * YEAR_W'(100);
            // divisible by 400 iff divisible by 100 with a quotient divisible by 4
            return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
        end
    endfunction

    function automatic logic [DAY_W-1:0] f_dim(input logic [YEAR_W-1:0] y,
                                               input logic [MONTH_W-1:0] m);
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
                4'd2:    return f_leap(y) ? 5'd29 : 5'd28;
                default: return 5'd0;
            endcase
        end
    endfunction

    // days in a common year before the first of month m
    function automatic logic [8:0] f_days_before_month(input logic [MONTH_W-1:0] m);
        begin
            case (m)
                4'd1:    return 9'd0;
                4'd2:    return 9'd31;
                4'd3:    return 9'd59;
                4'd4:    return 9'd90;
                4'd5:    return 9'd120;
                4'd6:    return 9'd151;
                4'd7:    return 9'd181;
                4'd8:    return 9'd212;
                4'd9:    return 9'd243;
                4'd10:   return 9'd273;
                4'd11:   return 9'd304;
                4'd12:   return 9'd334;
                default: return 9'd0;
            endcase
        end
    endfunction

    function automatic logic f_date_ok(input t_date d);
        logic [DAY_W-1:0] dim;
        begin
            dim = f_dim(d.year, d.month);
            return (d.year >= MIN_YEAR) && (d.year <= MAX_YEAR) && (dim != '0)
                && (d.day >= FIRST_DAY) && (d.day <= dim);
        end
    endfunction

endpackage

FILE: design/gdds_serial.sv
// two-stage unit turning a valid date into its serial day number
module gdds_serial
    import gdds_pkg::*;
(
    input  logic             i_clk,
    input  t_date            i_date,
    output logic [SER_W-1:0] o_serial
);

    logic [YEAR_W-1:0] w_p;
    logic [YEAR_W-1:0] r_p;
    logic [7:0]        r_q100;
    logic              r_leap_adj;
    logic [9:0]        r_before;
    logic [SER_W-1:0]  r_serial;

    assign w_p = i_date.year - 14'd1;

    // stage 1: quotient by 100, leap-day term, days before the month plus day
    always_ff @(posedge i_clk) begin
        r_p        <= w_p;
        r_q100     <= f_div100(w_p);
        r_leap_adj <= f_leap(i_date.year) && (i_date.month > FEBRUARY);
        r_before   <= 10'(f_days_before_month(i_date.month)) + 10'(i_date.day);
    end

    // stage 2: 365p + p/4 - p/100 + p/400 + rest
    always_ff @(posedge i_clk) begin
        r_serial <= SER_W'(r_p) * SER_W'(365) + SER_W'(r_p[YEAR_W-1:2])
                  - SER_W'(r_q100) + SER_W'(r_q100[7:2])
                  + SER_W'(r_before) + SER_W'(r_leap_adj);
    end

    assign o_serial = r_serial;

endmodule

FILE: design/gregorian_date_day_shifter_top.sv
// top level: gregorian date register with load, day shift and date compare
// a load, kind 3 or an invalid compare goes from the decode state straight to the result
// a valid compare steps through the compare states S_CMP0 to S_CMP3; a shift walks month by month
// one item at a time: the next item is taken the cycle after the result transfer
// the month walk (one add and compare per cycle) sets the shift time
// reset: synchronous, active low; date returns to 0001-01-01, no result pending
module gregorian_date_day_shifter_top
    import gdds_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_kind,
    input  logic [YEAR_W-1:0]         i_year_in,
    input  logic [MONTH_W-1:0]        i_month_in,
    input  logic [DAY_W-1:0]          i_day_in,
    input  logic signed [OFF_W-1:0]   i_offset_days,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [YEAR_W-1:0]         o_year_out,
    output logic [MONTH_W-1:0]        o_month_out,
    output logic [DAY_W-1:0]          o_day_out,
    output logic                      o_is_less,
    output logic                      o_is_equal,
    output logic [DIST_W-1:0]         o_distance,
    output logic [1:0]                o_status
);

    // sequencer state
    t_state r_state, n_state;

    // captured item
    t_kind                   r_kind, n_kind;
    t_date                   r_given, n_given;
    logic signed [OFF_W-1:0] r_off, n_off;

    // current date, the only state that survives between items
    t_date r_cur, n_cur;

    // month walk working registers
    logic [YEAR_W-1:0]         r_wy, n_wy;
    logic [MONTH_W-1:0]        r_wm, n_wm;
    logic signed [WDAY_W-1:0]  r_wd, n_wd;

    // compare path
    logic [SER_W-1:0] r_ser_a, n_ser_a;

    // result registers
    logic              r_less, n_less;
    logic              r_eq, n_eq;
    logic [DIST_W-1:0] r_dist, n_dist;
    t_status           r_status, n_status;

    // combinational helpers
    logic                     w_given_ok;
    logic [DAY_W-1:0]         w_dim;
    logic [MONTH_W-1:0]       w_pm;
    logic [YEAR_W-1:0]        w_py;
    logic [DAY_W-1:0]         w_pdim;
    logic                     w_over;
    logic                     w_under;
    logic                     w_top_edge;
    logic                     w_bottom_edge;
    t_date                    w_ser_in;
    logic [SER_W-1:0]         w_serial;
    logic [SER_W-1:0]         w_diff;

    assign w_given_ok = f_date_ok(r_given);

    // length of the walk month and of the month before it
    assign w_dim  = f_dim(r_wy, r_wm);
    assign w_pm   = (r_wm == JANUARY) ? DECEMBER : r_wm - 4'd1;
    assign w_py   = (r_wm == JANUARY) ? r_wy - 14'd1 : r_wy;
    assign w_pdim = f_dim(w_py, w_pm);

    assign w_over        = r_wd > $signed(WDAY_W'(w_dim));
    assign w_under       = r_wd < $signed(WDAY_W'(FIRST_DAY));
    assign w_top_edge    = (r_wm == DECEMBER) && (r_wy == MAX_YEAR);
    assign w_bottom_edge = (r_wm == JANUARY) && (r_wy == MIN_YEAR);

    // serial unit sees the current date first, the given date the cycle after
    assign w_ser_in = (r_state == S_CMP0) ? r_cur : r_given;

    gdds_serial u_serial (
        .i_clk    (i_clk),
        .i_date   (w_ser_in),
        .o_serial (w_serial)
    );

    assign w_diff = (r_ser_a < w_serial) ? w_serial - r_ser_a : r_ser_a - w_serial;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_kind)
                    KIND_SHIFT: n_state = S_WALK;
                    KIND_CMP:   n_state = w_given_ok ? S_CMP0 : S_OUT;
                    default:    n_state = S_OUT;
                endcase
            end
            S_WALK: begin
                if (w_over) begin
                    if (w_top_edge) n_state = S_OUT;
                end else if (w_under) begin
                    if (w_bottom_edge) n_state = S_OUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CMP0: n_state = S_CMP1;
            S_CMP1: n_state = S_CMP2;
            S_CMP2: n_state = S_CMP3;
            S_CMP3: n_state = S_OUT;
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result values
    always_comb begin
        n_kind   = r_kind;
        n_given  = r_given;
        n_off    = r_off;
        n_cur    = r_cur;
        n_wy     = r_wy;
        n_wm     = r_wm;
        n_wd     = r_wd;
        n_ser_a  = r_ser_a;
        n_less   = r_less;
        n_eq     = r_eq;
        n_dist   = r_dist;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind        = t_kind'(i_kind);
                    n_given.year  = i_year_in;
                    n_given.month = i_month_in;
                    n_given.day   = i_day_in;
                    n_off         = i_offset_days;
                end
            end
            S_DECODE: begin
                n_less   = 1'b0;
                n_eq     = 1'b0;
                n_dist   = '0;
                n_status = ST_OK;
                case (r_kind)
                    KIND_LOAD: begin
                        if (w_given_ok) n_cur = r_given;
                        else            n_status = ST_INVALID;
                    end
                    KIND_SHIFT: begin
                        // day of month plus offset, resolved by walking months
                        n_wy = r_cur.year;
                        n_wm = r_cur.month;
                        n_wd = $signed(WDAY_W'(r_cur.day)) + WDAY_W'(r_off);
                    end
                    KIND_CMP: begin
                        if (!w_given_ok) n_status = ST_INVALID;
                    end
                    default: n_status = ST_INVALID;
                endcase
            end
            S_WALK: begin
                if (w_over) begin
                    if (w_top_edge) begin
                        n_status = ST_RANGE;
                    end else begin
                        n_wd = r_wd - $signed(WDAY_W'(w_dim));
                        if (r_wm == DECEMBER) begin
                            n_wy = r_wy + 14'd1;
                            n_wm = JANUARY;
                        end else begin
                            n_wm = r_wm + 4'd1;
                        end
                    end
                end else if (w_under) begin
                    if (w_bottom_edge) begin
                        n_status = ST_RANGE;
                    end else begin
                        n_wd = r_wd + $signed(WDAY_W'(w_pdim));
                        n_wy = w_py;
                        n_wm = w_pm;
                    end
                end else begin
                    n_cur.year  = r_wy;
                    n_cur.month = r_wm;
                    n_cur.day   = r_wd[DAY_W-1:0];
                end
            end
            S_CMP2: begin
                n_ser_a = w_serial;
            end
            S_CMP3: begin
                n_less = r_ser_a < w_serial;
                n_eq   = r_ser_a == w_serial;
                n_dist = (w_diff > SER_W'(DIST_MAX)) ? DIST_MAX : w_diff[DIST_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur.year  <= MIN_YEAR;
            r_cur.month <= JANUARY;
            r_cur.day   <= FIRST_DAY;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_given  <= n_given;
        r_off    <= n_off;
        r_wy     <= n_wy;
        r_wm     <= n_wm;
        r_wd     <= n_wd;
        r_ser_a  <= n_ser_a;
        r_less   <= n_less;
        r_eq     <= n_eq;
        r_dist   <= n_dist;
        r_status <= n_status;
    end

    // handshake: one item in flight, result held until its transfer
    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_year_out  = r_cur.year;
    assign o_month_out = r_cur.month;
    assign o_day_out   = r_cur.day;
    assign o_is_less   = r_less;
    assign o_is_equal  = r_eq;
    assign o_distance  = r_dist;
    assign o_status    = r_status;

endmodule

FILE: design/gdds_checker.sv
// port-level checks for the gregorian date day shifter, bound to the top level
module gdds_checker
    import gdds_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic [1:0]              i_kind,
    input logic [YEAR_W-1:0]       i_year_in,
    input logic [MONTH_W-1:0]      i_month_in,
    input logic [DAY_W-1:0]        i_day_in,
    input logic signed [OFF_W-1:0] i_offset_days,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic [YEAR_W-1:0]       o_year_out,
    input logic [MONTH_W-1:0]      o_month_out,
    input logic [DAY_W-1:0]        o_day_out,
    input logic                    o_is_less,
    input logic                    o_is_equal,
    input logic [DIST_W-1:0]       o_distance,
    input logic [1:0]              o_status
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_year_out) && $stable(o_month_out)
            && $stable(o_day_out) && $stable(o_distance) && $stable(o_status))
        else $error("result changed while stalled");

    // only one item in flight
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input taken while a result is pending");

    // compare fields are clear on any failed item
    a_fail_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> !o_is_less && !o_is_equal && (o_distance == '0))
        else $error("compare fields set on failed item");

    // equal dates have no distance and no ordering
    a_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_equal |-> !o_is_less && (o_distance == '0))
        else $error("inconsistent equal result");

    // the reported date always has its year and month in range and a nonzero day
    a_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year_out >= MIN_YEAR) && (o_year_out <= MAX_YEAR)
            && (o_month_out >= JANUARY) && (o_month_out <= DECEMBER)
            && (o_day_out >= FIRST_DAY))
        else $error("current date out of range");

endmodule

bind gregorian_date_day_shifter_top gdds_checker u_gdds_checker (.*);

FILE: test/testbench.sv
// self-checking testbench for the gregorian date day shifter: directed and random items
module testbench;
    import gdds_pkg::*;

    // one transfer into the block, fields as seen on its input ports
    typedef struct packed {
        t_kind                     kind;
        logic [YEAR_W-1:0]         year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic signed [OFF_W-1:0]   offset;
    } t_day_item;

    // one result transfer; the date is the current date after the item
    typedef struct packed {
        t_date                     date;
        logic                      is_less;
        logic                      is_equal;
        logic [DIST_W-1:0]         distance;
        t_status                   status;
    } t_day_result;

    // receiver ready behavior, picked at random each time the mode count runs out
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY
    } t_rx_mode;

    localparam int N_RANDOM     = 245;
    localparam int DRAIN_CYCLES = 20;    // idle time after the last result
    localparam int HOLD_CYCLES  = 500;   // long receiver hold-off
    localparam int HOLD_AFTER   = 40;    // result transfers seen before the hold-off starts

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [1:0]               i_kind = '0;
    logic [YEAR_W-1:0]        i_year_in = '0;
    logic [MONTH_W-1:0]       i_month_in = '0;
    logic [DAY_W-1:0]         i_day_in = '0;
    logic signed [OFF_W-1:0]  i_offset_days = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [YEAR_W-1:0]        o_year_out;
    logic [MONTH_W-1:0]       o_month_out;
    logic [DAY_W-1:0]         o_day_out;
    logic                     o_is_less;
    logic                     o_is_equal;
    logic [DIST_W-1:0]        o_distance;
    logic [1:0]               o_status;

    gregorian_date_day_shifter_top uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_day_item   pending_items[$];      // items waiting for the driver
    t_day_result expected_results[$];   // predicted results not yet seen
    // date while building stimulus
    t_date       plan_date = '{year: 14'd1, month: 4'd1, day: 5'd1};
    // date as the block should hold it
    t_date       tracked_date = '{year: 14'd1, month: 4'd1, day: 5'd1};
    int          mismatch_count = 0;

    // ---------------------------------------------------------------
    // calendar arithmetic for the prediction
    // ---------------------------------------------------------------

    function automatic bit year_has_leap_day(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // zero for a month outside 1..12
    function automatic int month_days(int y, int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return year_has_leap_day(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // days in all the years ahead of year y
    function automatic longint days_to_year(int y);
        longint p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    // day number, 0001-01-01 is day 1
    function automatic longint day_number(t_date d);
        longint s;
        s = days_to_year(int'(d.year));
        for (int k = 1; k < int'(d.month); k++)
            s += month_days(int'(d.year), k);
        return s + longint'(d.day);
    endfunction

    function automatic t_date date_from_number(longint s);
        int     yy;
        int     mm;
        longint r;
        t_date  d;
        yy = int'(((s - 1) * 400) / 146097) + 1;
        if (yy < 1)
            yy = 1;
        while (days_to_year(yy + 1) < s)
            yy++;
        while (yy > 1 && days_to_year(yy) >= s)
            yy--;
        r = s - days_to_year(yy);
        mm = 1;
        while (mm < 12 && r > month_days(yy, mm)) begin
            r -= month_days(yy, mm);
            mm++;
        end
        d.year = YEAR_W'(yy);
        d.month = MONTH_W'(mm);
        d.day = DAY_W'(r);
        return d;
    endfunction

    function automatic bit date_valid(t_date d);
        if (d.year < 1 || d.year > MAX_YEAR)
            return 1'b0;
        if (d.month < 1 || d.month > 12)
            return 1'b0;
        return d.day >= 1 && int'(d.day) <= month_days(int'(d.year), int'(d.month));
    endfunction

    function automatic longint last_day_number();
        return days_to_year(int'(MAX_YEAR) + 1);
    endfunction

    // result of one item on date cur; the new current date is in the result
    function automatic t_day_result advance_calendar(t_date cur, t_day_item it);
        t_day_result res;
        t_date       given;
        longint      s;
        longint      a;
        longint      b;
        longint      diff;
        given = '{year: it.year, month: it.month, day: it.day};
        res = '0;
        res.date = cur;
        res.status = ST_OK;
        case (it.kind)
            KIND_LOAD: begin
                if (date_valid(given))
                    res.date = given;
                else
                    res.status = ST_INVALID;
            end
            KIND_SHIFT: begin
                s = day_number(cur) + longint'(it.offset);
                if (s < 1 || s > last_day_number())
                    res.status = ST_RANGE;
                else
                    res.date = date_from_number(s);
            end
            KIND_CMP: begin
                if (date_valid(given)) begin
                    a = day_number(cur);
                    b = day_number(given);
                    diff = (a < b) ? b - a : a - b;
                    res.is_less = a < b;
                    res.is_equal = a == b;
                    res.distance = (diff > longint'(DIST_MAX)) ? DIST_MAX : DIST_W'(diff);
                end else begin
                    res.status = ST_INVALID;
                end
            end
            default: res.status = ST_INVALID;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    function automatic t_day_item make_item(t_kind k, int y, int m, int d, int off);
        t_day_item it;
        it.kind = k;
        it.year = YEAR_W'(y);
        it.month = MONTH_W'(m);
        it.day = DAY_W'(d);
        it.offset = OFF_W'(off);
        return it;
    endfunction

    // anything the 17-bit offset field can carry
    function automatic int raw_offset();
        return int'($urandom_range(0, 131071)) - 65536;
    endfunction

    // item with fields drawn over their whole width
    function automatic t_day_item raw_item(t_kind k);
        return make_item(k, $urandom_range(0, 16383), $urandom_range(0, 15),
                         $urandom_range(0, 31), raw_offset());
    endfunction

    // valid date, weighted toward the year limits, leap rules and month ends
    function automatic t_date pick_date();
        t_date d;
        int    y;
        int    m;
        int    sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            y = $urandom_range(1, 3);
        else if (sel < 4)
            y = $urandom_range(9996, 9999);
        else if (sel == 4)
            y = 4 * $urandom_range(1, 2499);
        else if (sel == 5)
            y = 100 * $urandom_range(1, 99);
        else
            y = $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        d.year = YEAR_W'(y);
        d.month = MONTH_W'(m);
        if ($urandom_range(0, 9) < 3)
            d.day = DAY_W'(month_days(y, m));
        else
            d.day = DAY_W'($urandom_range(1, month_days(y, m)));
        return d;
    endfunction

    // shift size: mostly short walks, some medium, a few over the full field
    function automatic int pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return int'($urandom_range(0, 800)) - 400;
        else if (r < 88)
            return int'($urandom_range(0, 8000)) - 4000;
        return raw_offset();
    endfunction

    // queue one item and follow the date it leaves behind
    task automatic queue_item(t_day_item it);
        t_day_result res;
        res = advance_calendar(plan_date, it);
        plan_date = res.date;
        pending_items.push_back(it);
    endtask

    task automatic queue_date(t_kind k, t_date d, int off);
        queue_item(make_item(k, int'(d.year), int'(d.month), int'(d.day), off));
    endtask

    // ---------------------------------------------------------------
    // driver: bursts of transfers with random gaps
    // ---------------------------------------------------------------

    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_day_item next_item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            // nothing offered, or the offered item transfers at this edge
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                next_item = pending_items.pop_front();
                i_valid <= 1'b1;
                i_kind <= next_item.kind;
                i_year_in <= next_item.year;
                i_month_in <= next_item.month;
                i_day_in <= next_item.day;
                i_offset_days <= next_item.offset;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    // long bursts now and then give stretches with no idling
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                              : $urandom_range(1, 8);
                    gap_left <= ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: ready pattern plus one long hold-off
    // ---------------------------------------------------------------

    t_rx_mode rx_mode = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    int       rx_transfers = 0;
    bit       hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                rx_transfers <= rx_transfers + 1;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else if (!hold_done && rx_transfers == HOLD_AFTER) begin
                // result sits unread; the block stays busy and its input stalls
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode <= t_rx_mode'($urandom_range(0, 2));
                    mode_left <= $urandom_range(16, 96);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (rx_mode)
                    RX_OPEN:  i_ready <= 1'b1;
                    RX_LIGHT: i_ready <= ($urandom_range(0, 3) != 0);
                    default:  i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: predict on input transfer, check on result transfer
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, t_day_result want, t_day_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected %0d-%0d-%0d less %0b equal %0b distance %0d status %0d",
                     what, want.date.year, want.date.month, want.date.day, want.is_less,
                     want.is_equal, want.distance, want.status);
            $display("    got %0d-%0d-%0d less %0b equal %0b distance %0d status %0d",
                     got.date.year, got.date.month, got.date.day, got.is_less,
                     got.is_equal, got.distance, got.status);
        end
    endtask

    always @(posedge i_clk) begin
        t_day_item   taken;
        t_day_result predicted;
        t_day_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                taken = make_item(t_kind'(i_kind), int'(i_year_in), int'(i_month_in),
                                  int'(i_day_in), int'(i_offset_days));
                predicted = advance_calendar(tracked_date, taken);
                tracked_date = predicted.date;
                expected_results.push_back(predicted);
            end
            if (o_valid && i_ready) begin
                got.date = '{year: o_year_out, month: o_month_out, day: o_day_out};
                got.is_less = o_is_less;
                got.is_equal = o_is_equal;
                got.distance = o_distance;
                got.status = t_status'(o_status);
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item pending", '0, got);
                end else begin
                    predicted = expected_results.pop_front();
                    if (got !== predicted)
                        report_mismatch("result mismatch", predicted, got);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus, reset and end of run
    // ---------------------------------------------------------------

    initial begin
        t_date d;
        longint s;
        int r;

        // directed: year limits, leap rule, bad fields, every kind
        queue_item(make_item(KIND_SHIFT, 0, 0, 0, -1));          // before 0001-01-01
        queue_item(make_item(KIND_CMP, 1, 1, 1, 0));             // equal dates
        queue_item(make_item(KIND_LOAD, 9999, 12, 31, 0));
        queue_item(make_item(KIND_SHIFT, 0, 0, 0, 1));           // past 9999-12-31
        queue_item(make_item(KIND_CMP, 1, 1, 1, 0));             // largest distance
        queue_item(make_item(KIND_CMP, 9999, 12, 31, 0));
        queue_item(make_item(KIND_LOAD, 0, 1, 1, 0));            // year zero
        queue_item(make_item(KIND_LOAD, 16383, 15, 31, -1));     // every field bit set
        queue_item(make_item(KIND_LOAD, 10000, 1, 1, 0));        // year too large
        queue_item(make_item(KIND_LOAD, 2023, 2, 29, 0));        // not a leap year
        queue_item(make_item(KIND_LOAD, 1900, 2, 29, 0));        // century, not leap
        queue_item(make_item(KIND_LOAD, 2000, 2, 29, 0));        // 400-year leap
        queue_item(make_item(KIND_SHIFT, 0, 0, 0, 65535));
        queue_item(make_item(KIND_SHIFT, 0, 0, 0, -65536));
        queue_item(make_item(KIND_LOAD, 2024, 4, 31, 0));        // day past a 30-day month
        queue_item(make_item(KIND_LOAD, 2024, 13, 1, 0));        // month past december
        queue_item(make_item(KIND_LOAD, 2024, 1, 0, 0));         // day zero
        queue_item(make_item(KIND_LOAD, 2024, 2, 29, 0));
        queue_item(make_item(KIND_SHIFT, 0, 0, 0, 366));
        queue_item(make_item(KIND_CMP, 2024, 2, 28, 0));         // current date later
        queue_item(make_item(KIND_CMP, 2100, 2, 29, 0));         // bad date to compare
        queue_item(make_item(KIND_NONE, 2024, 1, 1, 5));         // unused kind
        queue_item(make_item(KIND_SHIFT, 0, 0, 0, 0));
        queue_item(make_item(KIND_LOAD, 2023, 12, 31, 0));
        queue_item(make_item(KIND_SHIFT, 0, 0, 0, 1));           // carry into a new year

        // random: mostly valid loads, shifts and compares; some garbage and unused kind
        repeat (N_RANDOM) begin
            r = $urandom_range(0, 99);
            if (r < 24) begin
                queue_date(KIND_LOAD, pick_date(), raw_offset());
            end else if (r < 29) begin
                queue_item(raw_item(KIND_LOAD));
            end else if (r < 62) begin
                d = pick_date();
                queue_item(make_item(KIND_SHIFT, $urandom_range(0, 16383), $urandom_range(0, 15),
                                     $urandom_range(0, 31), pick_offset()));
            end else if (r < 84) begin
                case ($urandom_range(0, 2))
                    0: d = plan_date;
                    1: begin
                        s = day_number(plan_date) + longint'($urandom_range(0, 60)) - 30;
                        if (s < 1)
                            s = 1;
                        if (s > last_day_number())
                            s = last_day_number();
                        d = date_from_number(s);
                    end
                    default: d = pick_date();
                endcase
                queue_date(KIND_CMP, d, raw_offset());
            end else if (r < 92) begin
                queue_item(raw_item(KIND_CMP));
            end else begin
                queue_item(raw_item(KIND_NONE));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all items sent, then all results back, then a short drain
        while (pending_items.size() != 0 || i_valid)
            @(negedge i_clk);
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("[gregorian_date_day_shifter_top] OK");
        else
            $display("[gregorian_date_day_shifter_top] ERROR");
        $finish;
    end

    // hang guard: about 270 items at the slowest shift with every stall, several times over
    initial begin
        #30000000;
        $display("[gregorian_date_day_shifter_top] ERROR");
        $finish;
    end

endmodule

FILE: files.f
design/gdds_pkg.sv
design/gdds_serial.sv
design/gregorian_date_day_shifter_top.sv
design/gdds_checker.sv
test/testbench.sv
